FILE: hdl/chte_pkg.sv
// Shared constants, codes and helpers for the canonical Huffman table engine.
package chte_pkg;

    localparam int NUM_SYMBOLS_DEF = 256;
    localparam int MAX_LEN_DEF     = 15;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 4;
    localparam int CODE_W  = 15;
    localparam int CNT_W   = 9;
    localparam int NLEN    = 16;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int M_TDATA_W = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNUSED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd3;

    // Mask of the low l bits of a code.
    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] l);
        logic [CODE_W:0] m;
        m = (CODE_W+1)'(1) << l;
        return CODE_W'(m - (CODE_W+1)'(1));
    endfunction

endpackage

FILE: hdl/chte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/canonical_huffman_table_engine_core.sv
// Canonical Huffman table engine: table load and build, encode and decode lookups.
//
// Beats arrive on the s_ channel: s_tuser carries the mode (load, encode or
// decode), s_tdata the symbol, the code length and the bit window, and
// s_tlast marks the final load pair. Every load, encode and decode beat gives
// exactly one result beat on the m_ channel; a beat with the unused mode is
// taken and dropped. s_tready is high only while the sequencer is idle, so
// one beat is worked on at a time.
// A plain load goes through the finish state to its result. The load beat
// marked last then builds the table: one sweep over the length store to count
// each length, one step per length for the first codes and a second sweep
// that hands out codes and slots. The single read port of the length store
// sets these sweeps. An encode reads the length and code stores and then
// finishes. A decode tries one length per cycle through a shared subtract and
// compare, shortest first, up to the longest length in use.
// After reset every stored length reads as zero and no table is built; a
// new load after a build clears all lengths at once through per-symbol valid
// bits, so no clearing pass is needed. A finished result waits in the output
// register while m_tready is low; the next beat may still be taken, and the
// sequencer holds its next result until the output register is free.
module canonical_huffman_table_engine_core
    import chte_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
    parameter int MAX_LEN     = MAX_LEN_DEF,
    localparam int S_TDATA_W  = ((SYM_W + LEN_W + MAX_LEN + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // symbol [7:0], code_length [11:8], bit_window [MAX_LEN+11:12], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]    s_tuser,
    // last_pair
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_symbol [7:0], out_code [22:8], out_length [26:23], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [STAT_W-1:0]    m_tuser
);

    localparam int AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LEN_CAP = (MAX_LEN < 15) ? MAX_LEN : 15;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BCNT = 4'd1;
    localparam logic [3:0] S_BFC  = 4'd2;
    localparam logic [3:0] S_BASG = 4'd3;
    localparam logic [3:0] S_ENC  = 4'd4;
    localparam logic [3:0] S_ENC2 = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_DEC2 = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MAX_LEN-1:0] win_reg, win_next;
    logic [AW:0]        scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      psym_reg, psym_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [CNT_W-1:0]   slot_reg, slot_next;
    logic [CODE_W-1:0]  top_reg, top_next;
    logic [CODE_W-1:0]  mask_reg, mask_next;
    logic [NUM_SYMBOLS-1:0] valid_reg, valid_next;
    logic               ready_reg, ready_next;
    logic [LEN_W-1:0]   longest_reg, longest_next;

    logic [CNT_W-1:0]   cnt_reg  [NLEN];
    logic [CNT_W-1:0]   cnt_next [NLEN];
    logic [CODE_W-1:0]  fc_reg   [NLEN];
    logic [CODE_W-1:0]  fc_next  [NLEN];
    logic [CNT_W-1:0]   fs_reg   [NLEN];
    logic [CNT_W-1:0]   fs_next  [NLEN];
    logic [CODE_W-1:0]  nc_reg   [NLEN];
    logic [CODE_W-1:0]  nc_next  [NLEN];
    logic [CNT_W-1:0]   ns_reg   [NLEN];
    logic [CNT_W-1:0]   ns_next  [NLEN];

    // Result waiting for the output register.
    logic [STAT_W-1:0]  res_stat_reg, res_stat_next;
    logic [SYM_W-1:0]   res_sym_reg, res_sym_next;
    logic [CODE_W-1:0]  res_code_reg, res_code_next;
    logic [LEN_W-1:0]   res_len_reg, res_len_next;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [SYM_W-1:0]   out_sym_reg, out_sym_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;

    // Memory ports.
    logic               lm_we, cm_we, om_we;
    logic [AW-1:0]      lm_waddr, lm_raddr, cm_waddr, om_waddr, om_raddr;
    logic [LEN_W-1:0]   lm_wdata, lm_rdata;
    logic [CODE_W-1:0]  cm_wdata, cm_rdata;
    logic [SYM_W-1:0]   om_wdata, om_rdata;

    // Input fields.
    logic [SYM_W-1:0]   in_sym;
    logic [LEN_W-1:0]   in_len, in_len_cap;
    logic [MAX_LEN-1:0] in_win;
    logic               accept, in_range;

    // Shared decode step and sweep helpers.
    logic [CODE_W-1:0]  dec_top, dec_mask, dec_off, dec_slot;
    logic               dec_hit;
    logic [LEN_W-1:0]   p_len;
    logic [CODE_W:0]    fc_sum;
    logic [CODE_W-1:0]  fc_code;

    assign in_sym  = s_tdata[SYM_W-1:0];
    assign in_len  = s_tdata[SYM_W+LEN_W-1:SYM_W];
    assign in_win  = s_tdata[SYM_W+LEN_W+MAX_LEN-1:SYM_W+LEN_W];
    assign in_len_cap = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;
    assign in_range = {1'b0, in_sym} < (SYM_W+1)'(NUM_SYMBOLS);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // One decode trial: take the next window bit and compare against this length.
    assign dec_top  = {top_reg[CODE_W-2:0], win_reg[MAX_LEN-1]};
    assign dec_mask = {mask_reg[CODE_W-2:0], 1'b1};
    assign dec_off  = (dec_top - fc_reg[len_reg]) & dec_mask;
    assign dec_hit  = dec_off < CODE_W'(cnt_reg[len_reg]);
    assign dec_slot = CODE_W'(fs_reg[len_reg]) + dec_off;

    // Length of the symbol read on the previous sweep step; a symbol not loaded since the
    // last clear counts as unused.
    assign p_len = valid_reg[psym_reg] ? lm_rdata : '0;

    assign fc_sum  = ({1'b0, code_reg} + (CODE_W+1)'(cnt_reg[len_reg - LEN_W'(1)])) << 1;
    assign fc_code = fc_sum[CODE_W-1:0] & len_mask(len_reg);

    always_comb begin
        lm_we    = accept && (s_tuser == MODE_LOAD) && in_range;
        lm_waddr = in_sym[AW-1:0];
        lm_wdata = in_len_cap;
        lm_raddr = (state_reg == S_BCNT || state_reg == S_BASG) ?
                   scan_reg[AW-1:0] : sym_reg[AW-1:0];
        cm_we    = (state_reg == S_BASG) && pend_reg && (p_len != '0);
        cm_waddr = psym_reg;
        cm_wdata = nc_reg[p_len];
        om_we    = cm_we;
        om_waddr = ns_reg[p_len][AW-1:0];
        om_wdata = SYM_W'(psym_reg);
        om_raddr = dec_slot[AW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        sym_next     = sym_reg;
        len_next     = len_reg;
        win_next     = win_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        psym_next    = psym_reg;
        code_next    = code_reg;
        slot_next    = slot_reg;
        top_next     = top_reg;
        mask_next    = mask_reg;
        valid_next   = valid_reg;
        ready_next   = ready_reg;
        longest_next = longest_reg;
        cnt_next     = cnt_reg;
        fc_next      = fc_reg;
        fs_next      = fs_reg;
        nc_next      = nc_reg;
        ns_next      = ns_reg;
        res_stat_next = res_stat_reg;
        res_sym_next  = res_sym_reg;
        res_code_next = res_code_reg;
        res_len_next  = res_len_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_sym_next   = out_sym_reg;
        out_code_next  = out_code_reg;
        out_len_next   = out_len_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sym_next = in_sym;
                    res_stat_next = ST_OK;
                    res_sym_next  = in_sym;
                    res_code_next = '0;
                    res_len_next  = '0;
                    case (s_tuser)
                        MODE_LOAD: begin
                            // A load after a build starts a fresh table.
                            if (ready_reg) begin
                                valid_next = '0;
                                ready_next = 1'b0;
                            end
                            if (in_range) begin
                                valid_next[in_sym[AW-1:0]] = 1'b1;
                                res_len_next = in_len_cap;
                            end
                            if (s_tlast) begin
                                for (int i = 0; i < NLEN; i++) begin
                                    cnt_next[i] = '0;
                                end
                                longest_next = '0;
                                scan_next    = '0;
                                pend_next    = 1'b0;
                                state_next   = S_BCNT;
                            end else begin
                                state_next = S_FIN;
                            end
                        end
                        MODE_ENCODE: begin
                            if (!ready_reg) begin
                                res_stat_next = ST_NOT_BUILT;
                                state_next    = S_FIN;
                            end else if (!in_range) begin
                                res_stat_next = ST_UNUSED;
                                state_next    = S_FIN;
                            end else begin
                                state_next = S_ENC;
                            end
                        end
                        MODE_DECODE: begin
                            res_sym_next = '0;
                            win_next  = in_win;
                            len_next  = LEN_W'(1);
                            top_next  = '0;
                            mask_next = '0;
                            if (!ready_reg) begin
                                res_stat_next = ST_NOT_BUILT;
                                state_next    = S_FIN;
                            end else if (longest_reg == '0) begin
                                res_stat_next = ST_NO_MATCH;
                                state_next    = S_FIN;
                            end else begin
                                state_next = S_DEC;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BCNT, S_BASG: begin
                if (scan_reg < (AW+1)'(NUM_SYMBOLS)) begin
                    scan_next = scan_reg + (AW+1)'(1);
                    psym_next = scan_reg[AW-1:0];
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && p_len != '0) begin
                    if (state_reg == S_BCNT) begin
                        cnt_next[p_len] = cnt_reg[p_len] + CNT_W'(1);
                    end else begin
                        nc_next[p_len] = (nc_reg[p_len] + CODE_W'(1)) & len_mask(p_len);
                        ns_next[p_len] = ns_reg[p_len] + CNT_W'(1);
                    end
                end
                if (scan_reg == (AW+1)'(NUM_SYMBOLS) && !pend_reg) begin
                    if (state_reg == S_BCNT) begin
                        len_next   = LEN_W'(1);
                        code_next  = '0;
                        slot_next  = '0;
                        state_next = S_BFC;
                    end else begin
                        ready_next = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_BFC: begin
                fc_next[len_reg] = fc_code;
                nc_next[len_reg] = fc_code;
                fs_next[len_reg] = slot_reg;
                ns_next[len_reg] = slot_reg;
                code_next = fc_code;
                slot_next = slot_reg + cnt_reg[len_reg];
                if (cnt_reg[len_reg] != '0) begin
                    longest_next = len_reg;
                end
                if (len_reg == LEN_W'(NLEN - 1)) begin
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_BASG;
                end else begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_ENC: begin
                state_next = S_ENC2;
            end
            S_ENC2: begin
                if (!valid_reg[sym_reg[AW-1:0]] || lm_rdata == '0) begin
                    res_stat_next = ST_UNUSED;
                end else begin
                    res_code_next = cm_rdata;
                    res_len_next  = lm_rdata;
                end
                state_next = S_FIN;
            end
            S_DEC: begin
                top_next  = dec_top;
                mask_next = dec_mask;
                win_next  = win_reg << 1;
                if (dec_hit) begin
                    state_next = S_DEC2;
                end else if (len_reg >= longest_reg) begin
                    res_stat_next = ST_NO_MATCH;
                    state_next    = S_FIN;
                end else begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_DEC2: begin
                res_sym_next  = om_rdata;
                res_code_next = top_reg;
                res_len_next  = len_reg;
                state_next    = S_FIN;
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_sym_next   = res_sym_reg;
                    out_code_next  = res_code_reg;
                    out_len_next   = res_len_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            ready_reg     <= 1'b0;
            longest_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NLEN; i++) begin
                cnt_reg[i] <= '0;
                fc_reg[i]  <= '0;
                fs_reg[i]  <= '0;
            end
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            ready_reg     <= ready_next;
            longest_reg   <= longest_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            fc_reg        <= fc_next;
            fs_reg        <= fs_next;
        end
        sym_reg      <= sym_next;
        len_reg      <= len_next;
        win_reg      <= win_next;
        scan_reg     <= scan_next;
        psym_reg     <= psym_next;
        code_reg     <= code_next;
        slot_reg     <= slot_next;
        top_reg      <= top_next;
        mask_reg     <= mask_next;
        nc_reg       <= nc_next;
        ns_reg       <= ns_next;
        res_stat_reg <= res_stat_next;
        res_sym_reg  <= res_sym_next;
        res_code_reg <= res_code_next;
        res_len_reg  <= res_len_next;
        out_stat_reg <= out_stat_next;
        out_sym_reg  <= out_sym_next;
        out_code_reg <= out_code_next;
        out_len_reg  <= out_len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = M_TDATA_W'({out_len_reg, out_code_reg, out_sym_reg});

    // Stored length of each symbol.
    chte_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SYMBOLS)) u_len_ram (
        .aclk  (aclk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    // Canonical code of each symbol.
    chte_ram #(.WIDTH(CODE_W), .DEPTH(NUM_SYMBOLS)) u_code_ram (
        .aclk  (aclk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (sym_reg[AW-1:0]),
        .rdata (cm_rdata)
    );

    // Symbols in canonical order, by length and then by value.
    chte_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS)) u_order_ram (
        .aclk  (aclk),
        .we    (om_we),
        .waddr (om_waddr),
        .wdata (om_wdata),
        .raddr (om_raddr),
        .rdata (om_rdata)
    );

endmodule

FILE: bench/tb_canonical_huffman_table_engine_core.sv
// Self-checking bench for the canonical Huffman table engine core.
module tb_canonical_huffman_table_engine_core;
    import chte_pkg::*;

    localparam int NSYM = 256;
    localparam int MLEN = 15;
    localparam int SDW  = ((SYM_W + LEN_W + MLEN + 7) / 8) * 8;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic [CODE_W-1:0] window;
    } beat_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } beat_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic [MODE_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    always #5 aclk = ~aclk;

    canonical_huffman_table_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state: a shadow copy of the engine's tables.
    logic [LEN_W-1:0]  sym_len   [NSYM];
    logic [CODE_W-1:0] sym_code  [NSYM];
    logic [SYM_W-1:0]  slot_sym  [NSYM];
    logic [CNT_W-1:0]  len_count [NLEN];
    logic [CODE_W-1:0] len_first [NLEN];
    logic [CNT_W-1:0]  len_slot  [NLEN];
    logic [LEN_W-1:0]  longest;
    logic              built;

    beat_out_t expected_results[$];
    int errors = 0;
    int mismatches = 0;
    bit stim_done = 1'b0;

    function automatic logic [CODE_W-1:0] low_bits(int l);
        return CODE_W'((32'd1 << l) - 1);
    endfunction

    function automatic void build_codes();
        int code, prev, slot;
        code = 0; prev = 0; slot = 0;
        longest = '0;
        for (int l = 0; l < NLEN; l++) begin
            len_count[l] = '0; len_first[l] = '0; len_slot[l] = '0;
        end
        for (int l = 1; l <= 15; l++) begin
            code = ((code + prev) << 1) & low_bits(l);
            len_first[l] = CODE_W'(code);
            len_slot[l] = CNT_W'(slot);
            for (int s = 0; s < NSYM; s++) begin
                if (sym_len[s] == l) begin
                    slot_sym[slot & 8'hFF] = SYM_W'(s);
                    sym_code[s] = CODE_W'((code + len_count[l]) & low_bits(l));
                    len_count[l]++;
                    slot++;
                end
            end
            prev = len_count[l];
            if (prev != 0) longest = LEN_W'(l);
        end
        built = 1'b1;
    endfunction

    // Works out the result of one accepted beat; false for the unused mode.
    function automatic bit predict_lookup(beat_in_t b, output beat_out_t r);
        int top, off;
        logic [LEN_W-1:0] l;
        r = '0;
        case (b.mode)
            MODE_LOAD: begin
                if (built) begin
                    for (int s = 0; s < NSYM; s++) sym_len[s] = '0;
                    built = 1'b0;
                end
                l = (b.len > MLEN) ? LEN_W'(MLEN) : b.len;
                r.sym = b.sym;
                sym_len[b.sym] = l;
                r.len = l;
                if (b.last) build_codes();
                return 1'b1;
            end
            MODE_ENCODE: begin
                r.sym = b.sym;
                if (!built) r.status = ST_NOT_BUILT;
                else if (sym_len[b.sym] == 0) r.status = ST_UNUSED;
                else begin
                    r.code = sym_code[b.sym];
                    r.len = sym_len[b.sym];
                end
                return 1'b1;
            end
            MODE_DECODE: begin
                if (!built) begin
                    r.status = ST_NOT_BUILT;
                    return 1'b1;
                end
                for (int k = 1; k <= longest; k++) begin
                    top = (b.window >> (MLEN - k)) & low_bits(k);
                    off = (top - len_first[k]) & low_bits(k);
                    if (off < len_count[k]) begin
                        r.sym = slot_sym[(len_slot[k] + off) & 8'hFF];
                        r.code = CODE_W'(top);
                        r.len = LEN_W'(k);
                        return 1'b1;
                    end
                end
                r.status = ST_NO_MATCH;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // s_tvalid is only dropped when an idle gap follows, so it never gets
    // two updates at the same edge.
    task automatic send_beat(beat_in_t b);
        beat_out_t r;
        int idle;
        idle = $urandom_range(0, 15);
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.mode;
        s_tlast  <= b.last;
        s_tdata  <= SDW'({b.window, b.len, b.sym});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_lookup(b, r)) expected_results.push_back(r);
    endtask

    // Result side: random back-pressure, with calm stretches.
    initial begin
        int stall;
        beat_out_t got, want;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = '{m_tuser, m_tdata[7:0], m_tdata[22:8], m_tdata[26:23]};
            if (expected_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display({"mismatch: expected st=%0d sym=%h code=%h len=%0d, ",
                                  "got st=%0d sym=%h code=%h len=%0d"},
                                 want.status, want.sym, want.code, want.len,
                                 got.status, got.sym, got.code, got.len);
                end
            end
        end
    end

    // Directed rows: mode, symbol, length, last, window, check flag, fixed result.
    typedef struct {
        beat_in_t  b;
        bit        fixed;
        beat_out_t r;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(logic [1:0] m, int s, int l, bit la, int w,
                                bit f = 0, beat_out_t r = '0);
        row_t x;
        x.b = '{m, SYM_W'(s), LEN_W'(l), la, CODE_W'(w)};
        x.fixed = f;
        x.r = r;
        return x;
    endfunction

    task automatic load_random_table(bit well_formed);
        int n, lim;
        beat_in_t b;
        n = $urandom_range(1, 12);
        lim = $urandom_range(1, 15);
        for (int i = 0; i < n; i++) begin
            b = '{MODE_LOAD, SYM_W'($urandom), LEN_W'($urandom_range(0, lim)),
                  1'b0, CODE_W'($urandom)};
            if (well_formed && b.len == 0) b.len = 1;
            b.last = (i == n - 1);
            send_beat(b);
        end
    endtask

    initial begin
        beat_in_t b;
        row_t row;
        int loaded;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        built = 1'b0; longest = '0;
        for (int s = 0; s < NSYM; s++) begin
            sym_len[s] = '0; sym_code[s] = '0; slot_sym[s] = '0;
        end
        for (int l = 0; l < NLEN; l++) begin
            len_count[l] = '0; len_first[l] = '0; len_slot[l] = '0;
        end
        @(posedge aclk);

        // Lookups before any build, then a small table with extremes and a
        // repeated symbol, the empty table and mode 3.
        rows.push_back(mk(MODE_ENCODE, 255, 0, 0, 0, 1, '{ST_NOT_BUILT, 8'hFF, 0, 0}));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h7FFF, 1, '{ST_NOT_BUILT, 0, 0, 0}));
        rows.push_back(mk(2'd3, 1, 1, 1, 0));
        rows.push_back(mk(MODE_LOAD, 0, 1, 0, 0, 1, '{ST_OK, 0, 0, 1}));
        rows.push_back(mk(MODE_LOAD, 255, 15, 0, 15'h7FFF, 1, '{ST_OK, 8'hFF, 0, 15}));
        rows.push_back(mk(MODE_LOAD, 7, 3, 0, 0));
        rows.push_back(mk(MODE_LOAD, 7, 2, 0, 0));
        rows.push_back(mk(MODE_LOAD, 9, 2, 1, 0));
        rows.push_back(mk(MODE_ENCODE, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 1}));
        rows.push_back(mk(MODE_ENCODE, 7, 0, 0, 0));
        rows.push_back(mk(MODE_ENCODE, 255, 0, 0, 0));
        rows.push_back(mk(MODE_ENCODE, 3, 0, 0, 0, 1, '{ST_UNUSED, 3, 0, 0}));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h0000));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h7FFF));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h5555));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h6AAA));
        // Over-subscribed: three symbols of length one.
        rows.push_back(mk(MODE_LOAD, 1, 1, 0, 0));
        rows.push_back(mk(MODE_LOAD, 2, 1, 0, 0));
        rows.push_back(mk(MODE_LOAD, 3, 1, 1, 0));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h0000));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h4000));
        // Empty table.
        rows.push_back(mk(MODE_LOAD, 4, 0, 1, 0, 1, '{ST_OK, 4, 0, 0}));
        rows.push_back(mk(MODE_DECODE, 0, 0, 0, 15'h1234, 1, '{ST_NO_MATCH, 0, 0, 0}));
        rows.push_back(mk(MODE_ENCODE, 4, 0, 0, 0, 1, '{ST_UNUSED, 4, 0, 0}));

        foreach (rows[i]) begin
            row = rows[i];
            send_beat(row.b);
            // Typed-in results override the predictor's copy for the check.
            if (row.fixed) expected_results[$] = row.r;
        end

        // Random part: mostly loaded tables followed by lookups on them.
        loaded = rows.size();
        while (loaded < 550) begin
            load_random_table($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 20)) begin
                b = '{MODE_ENCODE, SYM_W'($urandom), LEN_W'($urandom),
                      1'($urandom), CODE_W'($urandom)};
                case ($urandom_range(0, 9))
                    0:       b.mode = 2'd3;
                    1, 2, 3: b.mode = MODE_ENCODE;
                    default: b.mode = MODE_DECODE;
                endcase
                send_beat(b);
                loaded++;
            end
            loaded += 6;
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
